/* hw/rtl/swcl_pkg.sv */
// Shared types, constants and helper functions of the sliding window call limiter.
// Used by swcl_cell, swcl_head and sliding_window_call_limiter; depends on nothing.
`default_nettype none

package swcl_pkg;

    localparam int MAX_RECORDS = 2048;
    localparam int NUM_FUNCS   = 32;
    localparam int CNT_W       = 12;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int STORE_W     = $clog2(MAX_RECORDS + 1);
    localparam int CFG_IDX_W   = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_MASK    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_PAIR_NRM = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_PAIR_INF = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_FUNC     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_CALLER   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_TOTAL    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 8'd7;

    localparam logic        RST_ENABLE       = 1'b1;
    localparam logic [31:0] RST_INFO_MASK    = 32'd147500;
    localparam logic [11:0] RST_LIM_PAIR_NRM = 12'd100;
    localparam logic [11:0] RST_LIM_PAIR_INF = 12'd300;
    localparam logic [11:0] RST_LIM_FUNC     = 12'd800;
    localparam logic [11:0] RST_LIM_CALLER   = 12'd1000;
    localparam logic [11:0] RST_LIM_TOTAL    = 12'd2000;
    localparam logic [15:0] RST_WINDOW       = 16'd60;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_INVALID  = 3'd2,
        ST_PAIR     = 3'd3,
        ST_FUNC     = 3'd4,
        ST_CALLER   = 3'd5,
        ST_TOTAL    = 3'd6,
        ST_FULL     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] caller;
        logic [7:0]  func;
        logic [31:0] stamp;
    } rec_t;

    typedef struct packed {
        logic        start;
        logic        step;
        logic        commit;
        logic [15:0] caller;
        logic [7:0]  func;
        logic [31:0] now;
        logic [31:0] window;
    } scan_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]   pair_cnt;
        logic [CNT_W-1:0]   func_cnt;
        logic [CNT_W-1:0]   caller_cnt;
        logic [STORE_W-1:0] stored;
        logic               pend_valid;
    } scan_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_total(input logic [STORE_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return (w > 32'(CNT_MAX)) ? CNT_MAX : w[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/swcl_cell.sv */
// One record cell of the rotating record ring.
// Depends on swcl_pkg for the record type.
`default_nettype none

module swcl_cell
    import swcl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift,
    input  wire rec_t d,
    output rec_t      q
);

    logic                        valid_reg;
    logic [$bits(rec_t)-2:0]     data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= {d.caller, d.func, d.stamp};
        end
    end

    assign q = {valid_reg, data_reg};

endmodule

`default_nettype wire

/* hw/rtl/swcl_head.sv */
// Head cell of the record ring: expiry, insertion of a pending record and match counting.
// Depends on swcl_pkg for the record, control and status types.
`default_nettype none

module swcl_head
    import swcl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire scan_ctrl_t ctrl,
    input  wire rec_t       ring_in,
    output rec_t            ring_out,
    output scan_stat_t      stat
);

    logic [CNT_W-1:0]   pair_reg, pair_next;
    logic [CNT_W-1:0]   func_reg, func_next;
    logic [CNT_W-1:0]   caller_reg, caller_next;
    logic [STORE_W-1:0] stored_reg, stored_next;
    logic               pend_valid_reg, pend_valid_next;
    rec_t               pend_reg;

    logic [31:0] age_r;
    logic [31:0] age_p;
    logic        exp_r;
    logic        exp_p;
    logic        ins;
    logic [1:0]  dec;
    logic        match_c;
    logic        match_f;

    always_comb
    begin
        age_r = ctrl.now - ring_in.stamp;
        age_p = ctrl.now - pend_reg.stamp;
        exp_r = ring_in.valid && (age_r > ctrl.window);
        exp_p = age_p > ctrl.window;
        ins   = 1'b0;
        ring_out = ring_in;
        if (ring_in.valid && !exp_r)
        begin
            ring_out = ring_in;
        end
        else if (pend_valid_reg)
        begin
            ins            = 1'b1;
            ring_out       = pend_reg;
            ring_out.valid = !exp_p;
        end
        else
        begin
            ring_out.valid = 1'b0;
        end
        dec     = 2'(exp_r) + 2'(ins && exp_p);
        match_c = ring_out.valid && (ring_out.caller == ctrl.caller);
        match_f = ring_out.valid && (ring_out.func == ctrl.func);
    end

    always_comb
    begin
        pair_next       = pair_reg;
        func_next       = func_reg;
        caller_next     = caller_reg;
        stored_next     = stored_reg;
        pend_valid_next = pend_valid_reg;
        if (ctrl.start)
        begin
            pair_next   = CNT_W'(1);
            func_next   = CNT_W'(1);
            caller_next = CNT_W'(1);
        end
        else if (ctrl.step)
        begin
            if (match_c)
            begin
                caller_next = sat_inc(caller_reg);
            end
            if (match_f)
            begin
                func_next = sat_inc(func_reg);
            end
            if (match_f && match_c)
            begin
                pair_next = sat_inc(pair_reg);
            end
            stored_next = stored_reg - STORE_W'(dec);
            if (ins)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (ctrl.commit)
        begin
            stored_next     = stored_reg + STORE_W'(1);
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg       <= '0;
            func_reg       <= '0;
            caller_reg     <= '0;
            stored_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pair_reg       <= pair_next;
            func_reg       <= func_next;
            caller_reg     <= caller_next;
            stored_reg     <= stored_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            pend_reg <= '{valid: 1'b1, caller: ctrl.caller, func: ctrl.func, stamp: ctrl.now};
        end
    end

    assign stat = '{pair_cnt: pair_reg, func_cnt: func_reg, caller_cnt: caller_reg,
                    stored: stored_reg, pend_valid: pend_valid_reg};

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_call_limiter.sv */
// Top level of the sliding window call limiter: control, configuration and the record ring.
// Depends on swcl_pkg, swcl_cell and swcl_head.
//
//   Channel   Signals                        Direction  Contents
//   s_*       s_tvalid s_tready s_tdata[55:0] in        caller_id, func_id, now_seconds
//   m_*       m_tvalid m_tready m_tdata[55:0] out       status and the four counts
//   cfg_*     cfg_valid cfg_ready cfg_index   in        register write, always ready
//
// A checked request rotates the records once through the ring past the single head
// cell, which expires, inserts and counts one record a cycle. A disabled or invalid
// request skips the scan and goes straight to the result. The record valid bits are cleared
// directly by reset, so requests are taken right after reset. A stalled result waits in
// the output register while the next request is already accepted and scanned.
`default_nettype none

module sliding_window_call_limiter
    import swcl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // caller_id[15:0], func_id[23:16], now_seconds[55:24]
    input  wire logic [55:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[2:0], pair_count[14:3], func_count[26:15], caller_count[38:27],
    // total_count[50:39], zero fill[55:51]
    output logic [55:0]               m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic        enable_reg;
    logic [31:0] info_mask_reg;
    logic [11:0] lim_pair_nrm_reg;
    logic [11:0] lim_pair_inf_reg;
    logic [11:0] lim_func_reg;
    logic [11:0] lim_caller_reg;
    logic [11:0] lim_total_reg;
    logic [15:0] window_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [15:0]      req_caller_reg;
    logic [7:0]       req_func_reg;
    logic [31:0]      req_now_reg;
    status_t          pre_status_reg, pre_status_next;

    logic             m_valid_reg, m_valid_next;
    logic [55:0]      m_data_reg;

    logic [15:0] in_caller;
    logic [7:0]  in_func;
    logic [31:0] in_now;
    logic        in_accept;
    logic        scan_last;
    logic        out_free;
    logic        out_load;
    logic        start;
    logic        step;
    logic        commit;

    scan_ctrl_t  ctrl;
    scan_stat_t  stat;
    rec_t        head_out;
    rec_t        ring_q [MAX_RECORDS];

    logic [11:0] pair_lim;
    logic [11:0] total12;
    logic        full;
    status_t     res_status;
    logic [55:0] res_data;

    assign in_caller = s_tdata[15:0];
    assign in_func   = s_tdata[23:16];
    assign in_now    = s_tdata[55:24];
    assign in_accept = s_tvalid && s_tready;
    assign scan_last = scan_cnt_reg == IDX_W'(MAX_RECORDS - 1);
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= RST_ENABLE;
            info_mask_reg    <= RST_INFO_MASK;
            lim_pair_nrm_reg <= RST_LIM_PAIR_NRM;
            lim_pair_inf_reg <= RST_LIM_PAIR_INF;
            lim_func_reg     <= RST_LIM_FUNC;
            lim_caller_reg   <= RST_LIM_CALLER;
            lim_total_reg    <= RST_LIM_TOTAL;
            window_reg       <= RST_WINDOW;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE:       enable_reg       <= cfg_data[0];
                REG_INFO_MASK:    info_mask_reg    <= cfg_data;
                REG_LIM_PAIR_NRM: lim_pair_nrm_reg <= cfg_data[11:0];
                REG_LIM_PAIR_INF: lim_pair_inf_reg <= cfg_data[11:0];
                REG_LIM_FUNC:     lim_func_reg     <= cfg_data[11:0];
                REG_LIM_CALLER:   lim_caller_reg   <= cfg_data[11:0];
                REG_LIM_TOTAL:    lim_total_reg    <= cfg_data[11:0];
                REG_WINDOW:       window_reg       <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pre_status_next = pre_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!enable_reg)
                    begin
                        state_next      = S_DONE;
                        pre_status_next = ST_DISABLED;
                    end
                    else if (in_func >= 8'(NUM_FUNCS))
                    begin
                        state_next      = S_DONE;
                        pre_status_next = ST_INVALID;
                    end
                    else
                    begin
                        state_next      = S_SCAN;
                        pre_status_next = ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        start    = 1'b0;
        step     = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                start    = s_tvalid;
            end
            S_SCAN:
            begin
                step = 1'b1;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        commit = out_load && (pre_status_reg == ST_OK) && (res_status == ST_OK);
    end

    always_comb
    begin
        pair_lim = info_mask_reg[req_func_reg[4:0]] ? lim_pair_inf_reg : lim_pair_nrm_reg;
        total12  = sat_total(stat.stored);
        full     = stat.stored == STORE_W'(MAX_RECORDS);
        if (pre_status_reg != ST_OK)
        begin
            res_status = pre_status_reg;
        end
        else if (stat.pair_cnt > pair_lim)
        begin
            res_status = ST_PAIR;
        end
        else if (stat.func_cnt > lim_func_reg)
        begin
            res_status = ST_FUNC;
        end
        else if (stat.caller_cnt > lim_caller_reg)
        begin
            res_status = ST_CALLER;
        end
        else if (total12 > lim_total_reg)
        begin
            res_status = ST_TOTAL;
        end
        else if (full)
        begin
            res_status = ST_FULL;
        end
        else
        begin
            res_status = ST_OK;
        end
        if (pre_status_reg != ST_OK)
        begin
            res_data = {53'd0, res_status};
        end
        else
        begin
            res_data = {5'd0, total12, stat.caller_cnt, stat.func_cnt, stat.pair_cnt,
                        res_status};
        end
    end

    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        if (start)
        begin
            scan_cnt_next = '0;
        end
        else if (step)
        begin
            scan_cnt_next = scan_cnt_reg + IDX_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            pre_status_reg <= ST_OK;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            pre_status_reg <= pre_status_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_caller_reg <= in_caller;
            req_func_reg   <= in_func;
            req_now_reg    <= in_now;
        end
        if (out_load)
        begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign ctrl = '{start: start, step: step, commit: commit, caller: req_caller_reg,
                    func: req_func_reg, now: req_now_reg, window: {16'd0, window_reg}};

    swcl_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ring_in  (ring_q[MAX_RECORDS-1]),
        .ring_out (head_out),
        .stat     (stat)
    );

    for (genvar gi = 0; gi < MAX_RECORDS; gi++)
    begin : g_ring
        if (gi == 0)
        begin : g_first
            swcl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .d     (head_out),
                .q     (ring_q[gi])
            );
        end
        else
        begin : g_rest
            swcl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .d     (ring_q[gi-1]),
                .q     (ring_q[gi])
            );
        end
    end

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stat.stored) <= 32'(MAX_RECORDS))
        else $error("stored record count exceeds the ring size");

    a_pend_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pre_status_reg == ST_OK) |-> !stat.pend_valid)
        else $error("pending record was not placed during the scan");

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> stat.stored == $past(stat.stored) + STORE_W'(1))
        else $error("accepted request did not raise the stored count");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == ST_DISABLED || m_tdata[2:0] == ST_INVALID))
        |-> m_tdata[55:3] == '0)
        else $error("rejected request reports nonzero counts");

endmodule

`default_nettype wire
